FILE: rtl/tgmc_pkg.sv
// Package for the tile grid motion clip block: grid geometry, codes and
// the structs shared between the register bank, controller and datapath.
// No dependencies.
package tgmc_pkg;

  // Grid geometry
  localparam int CELL_W     = 4;
  localparam int CELL_H     = 4;
  localparam int GRID_COLS  = 256;
  localparam int GRID_ROWS  = 64;
  localparam int PIX_W      = GRID_COLS * CELL_W;
  localparam int PIX_H      = GRID_ROWS * CELL_H;
  localparam int GRID_DEPTH = GRID_COLS * GRID_ROWS;
  localparam int ADDR_BITS  = $clog2(GRID_DEPTH);

  // Coordinates: wide enough for x + w - 1 + step with a sign bit
  localparam int COORD_BITS = 14;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] idx_t;
  typedef logic        [ADDR_BITS-1:0]  addr_t;

  // Operation codes
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLIP  = 2'd2;
  localparam logic [1:0] FN_NOP   = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MASK_LEFT   = 2'd0;
  localparam logic [1:0] REG_MASK_RIGHT  = 2'd1;
  localparam logic [1:0] REG_MASK_TOP    = 2'd2;
  localparam logic [1:0] REG_MASK_BOTTOM = 2'd3;

  localparam logic [7:0] RST_MASK_LEFT   = 8'd1;
  localparam logic [7:0] RST_MASK_RIGHT  = 8'd2;
  localparam logic [7:0] RST_MASK_TOP    = 8'd4;
  localparam logic [7:0] RST_MASK_BOTTOM = 8'd8;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [7:0]  cell_col;
    logic        [5:0]  cell_row;
    logic        [7:0]  cell_flags;
    logic        [9:0]  rect_x;
    logic        [7:0]  rect_y;
    logic        [10:0] rect_w;
    logic        [8:0]  rect_h;
    logic signed [3:0]  move_dx;
    logic signed [3:0]  move_dy;
  } req_t;

  typedef struct packed {
    logic signed [3:0] clipped_dx;
    logic signed [3:0] clipped_dy;
    logic        [7:0] read_flags;
  } rsp_t;

  typedef struct packed {
    logic [7:0] left_solid;
    logic [7:0] right_solid;
    logic [7:0] top_solid;
    logic [7:0] bottom_solid;
  } masks_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;       // clearing pass: zero one cell
    logic acc;          // request transfer: latch fields, write the cell on a write request
    logic re_cell;      // read the addressed cell
    logic re_scan;      // read the cell under the scan index
    logic start_x;      // begin column scan
    logic start_y;      // begin row scan
    logic scan_next;    // advance scan index
    logic hit_x;        // horizontal step stops at blocking cell
    logic hit_y;        // vertical step stops at blocking cell
    logic out_load;     // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       need_x;
    logic       need_y;
    logic       hit;
    logic       scan_last;
    logic       clr_last;
  } sts_t;

endpackage

FILE: rtl/tile_grid_motion_clip.sv
// Tile grid motion clip: a 256 x 64 grid of solidity flag bytes in 4 x 4 pixel
// cells, with cell write, cell read and rectangle motion clipping. After reset
// the block sweeps all 16384 cells to zero, one cell per cycle; no request
// transfer is taken during the sweep, while APB writes to the mask registers
// work at any time. A request takes one item at a time through a single-ported
// grid memory. A write, read or non-scanning clip passes through the decode and
// done states before the next request transfer. A clip that crosses a cell
// boundary scans the entered column over the rows the rectangle spans, then the
// entered row over its columns, each cell by a memory read, then a mask test;
// a scan ends at the first blocking cell, the last spanned cell or the grid edge.
// The result sits in an output register, so the next request transfer is taken
// while a result waits.
// Depends on tgmc_pkg, tgmc_regs, tgmc_ctrl, tgmc_dp.
module tile_grid_motion_clip
  import tgmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  masks_t masks;
  cmd_t   cmd;
  sts_t   sts;

  // direction masks
  tgmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .masks   (masks)
  );

  // sequencer
  tgmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // grid memory and clip arithmetic
  tgmc_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .masks (masks),
    .cmd   (cmd),
    .sts   (sts),
    .rsp   (rsp)
  );

endmodule

FILE: rtl/tgmc_regs.sv
// APB register bank holding the four direction masks.
// Depends on tgmc_pkg.
module tgmc_regs
  import tgmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output masks_t      masks
);

  logic       wr;
  logic [1:0] sel;
  logic [7:0] rd_val;

  assign wr     = psel && penable && pwrite;
  assign sel    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.left_solid   <= RST_MASK_LEFT;
      masks.right_solid  <= RST_MASK_RIGHT;
      masks.top_solid    <= RST_MASK_TOP;
      masks.bottom_solid <= RST_MASK_BOTTOM;
    end else if (wr) begin
      unique case (sel)
        REG_MASK_LEFT:   masks.left_solid   <= pwdata[7:0];
        REG_MASK_RIGHT:  masks.right_solid  <= pwdata[7:0];
        REG_MASK_TOP:    masks.top_solid    <= pwdata[7:0];
        REG_MASK_BOTTOM: masks.bottom_solid <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MASK_LEFT:   rd_val = masks.left_solid;
      REG_MASK_RIGHT:  rd_val = masks.right_solid;
      REG_MASK_TOP:    rd_val = masks.top_solid;
      REG_MASK_BOTTOM: rd_val = masks.bottom_solid;
      default:         rd_val = 8'd0;
    endcase
  end

  assign prdata = {24'd0, rd_val};

endmodule

FILE: rtl/tgmc_ctrl.sv
// Sequencer: clearing pass, request decode, column and row scans, result hand-off.
// Depends on tgmc_pkg.
module tgmc_ctrl
  import tgmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECODE = 8'b0000_0100,
    ST_X_RD   = 8'b0000_1000,
    ST_X_CHK  = 8'b0001_0000,
    ST_Y_RD   = 8'b0010_0000,
    ST_Y_CHK  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.acc    = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.func == FN_READ) begin
          cmd.re_cell = 1'b1;
          state_next  = ST_DONE;
        end else if (sts.func == FN_CLIP) begin
          if (sts.need_x) begin
            cmd.start_x = 1'b1;
            state_next  = ST_X_RD;
          end else if (sts.need_y) begin
            cmd.start_y = 1'b1;
            state_next  = ST_Y_RD;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_X_RD: begin
        cmd.re_scan = 1'b1;
        state_next  = ST_X_CHK;
      end
      ST_X_CHK: begin
        if (sts.hit || sts.scan_last) begin
          cmd.hit_x = sts.hit;
          if (sts.need_y) begin
            cmd.start_y = 1'b1;
            state_next  = ST_Y_RD;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_X_RD;
        end
      end
      ST_Y_RD: begin
        cmd.re_scan = 1'b1;
        state_next  = ST_Y_CHK;
      end
      ST_Y_CHK: begin
        if (sts.hit || sts.scan_last) begin
          cmd.hit_y  = sts.hit;
          state_next = ST_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_Y_RD;
        end
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign rsp_valid_next = cmd.out_load || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: rtl/tgmc_dp.sv
// Datapath: cell grid memory, request latch, step clamping, scan index and
// result register.
// Depends on tgmc_pkg.
module tgmc_dp
  import tgmc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  req_t   req,
  input  masks_t masks,
  input  cmd_t   cmd,
  output sts_t   sts,
  output rsp_t   rsp
);

  logic [7:0] grid [GRID_DEPTH];
  logic [7:0] rd_data;
  addr_t      clr_addr;
  addr_t      raddr;
  addr_t      req_addr;
  addr_t      cell_addr;
  addr_t      scan_addr;

  // latched request
  logic [1:0]  f_func;
  logic [7:0]  f_col;
  logic [5:0]  f_row;
  logic [9:0]  f_x;
  logic [7:0]  f_y;
  logic [10:0] f_w;
  logic [8:0]  f_h;
  coord_t      f_dx;
  coord_t      f_dy;
  coord_t      dx_in;
  coord_t      dy_in;

  coord_t xs, ys, ws, hs, x2, y2;
  coord_t nx_l, nx_r, ny_u, ny_d;
  coord_t cc_l, cc_r, nc_l, nc_r;
  coord_t cr_u, cr_d, nr_u, nr_d;
  coord_t x_free, x_blk, x_col;
  coord_t y_free, y_blk, y_row;
  coord_t dx_fin, dy_fin;
  logic   x_scan, y_scan;
  logic   req_ok, cell_ok;

  idx_t idx, scan_end, scan_lim;
  idx_t r0, r1, c0, c1;
  logic axis_y;
  logic x_hit, y_hit;
  logic [7:0] mask_sel;

  // ---------------- request latch ----------------
  always_comb begin
    dx_in = coord_t'(req.move_dx);
    dy_in = coord_t'(req.move_dy);
    if (dx_in > coord_t'(CELL_W))  dx_in = coord_t'(CELL_W);
    if (dx_in < coord_t'(-CELL_W)) dx_in = coord_t'(-CELL_W);
    if (dy_in > coord_t'(CELL_H))  dy_in = coord_t'(CELL_H);
    if (dy_in < coord_t'(-CELL_H)) dy_in = coord_t'(-CELL_H);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      f_func <= req.func;
      f_col  <= req.cell_col;
      f_row  <= req.cell_row;
      f_x    <= req.rect_x;
      f_y    <= req.rect_y;
      f_w    <= req.rect_w;
      f_h    <= req.rect_h;
      f_dx   <= dx_in;
      f_dy   <= dy_in;
    end
  end

  // ---------------- geometry ----------------
  assign xs = coord_t'(f_x);
  assign ys = coord_t'(f_y);
  assign ws = (f_w == 11'd0) ? coord_t'(1) : coord_t'(f_w);
  assign hs = (f_h == 9'd0)  ? coord_t'(1) : coord_t'(f_h);
  assign x2 = xs + ws - coord_t'(1);
  assign y2 = ys + hs - coord_t'(1);

  assign nx_l = xs + f_dx;
  assign nx_r = x2 + f_dx;
  assign ny_u = ys + f_dy;
  assign ny_d = y2 + f_dy;

  assign cc_l = coord_t'($unsigned(xs) / CELL_W);
  assign cc_r = coord_t'($unsigned(x2) / CELL_W);
  assign nc_l = coord_t'($unsigned(nx_l) / CELL_W);
  assign nc_r = coord_t'($unsigned(nx_r) / CELL_W);
  assign cr_u = coord_t'($unsigned(ys) / CELL_H);
  assign cr_d = coord_t'($unsigned(y2) / CELL_H);
  assign nr_u = coord_t'($unsigned(ny_u) / CELL_H);
  assign nr_d = coord_t'($unsigned(ny_d) / CELL_H);

  assign r0 = idx_t'(cr_u);
  assign r1 = idx_t'(cr_d);
  assign c0 = idx_t'(cc_l);
  assign c1 = idx_t'(cc_r);

  // horizontal step
  always_comb begin
    x_free = '0;
    x_blk  = '0;
    x_col  = '0;
    x_scan = 1'b0;
    if (f_dx < 0) begin
      if (nx_l < 0) begin
        x_free = -xs;
      end else begin
        x_free = f_dx;
        x_col  = nc_l;
        x_scan = (nc_l != cc_l);
        x_blk  = coord_t'(cc_l * CELL_W) - xs;
      end
    end else if (f_dx > 0) begin
      if (nx_r >= coord_t'(PIX_W)) begin
        x_free = coord_t'(PIX_W - 1) - x2;
        if (x_free < 0) x_free = '0;
      end else begin
        x_free = f_dx;
        x_col  = nc_r;
        x_scan = (nc_r != cc_r);
        x_blk  = coord_t'(nc_r * CELL_W) - x2 - coord_t'(1);
      end
    end
  end

  // vertical step
  always_comb begin
    y_free = '0;
    y_blk  = '0;
    y_row  = '0;
    y_scan = 1'b0;
    if (f_dy < 0) begin
      if (ny_u < 0) begin
        y_free = -ys;
      end else begin
        y_free = f_dy;
        y_row  = nr_u;
        y_scan = (nr_u != cr_u);
        y_blk  = coord_t'(cr_u * CELL_H) - ys;
      end
    end else if (f_dy > 0) begin
      if (ny_d >= coord_t'(PIX_H)) begin
        y_free = coord_t'(PIX_H - 1) - y2;
        if (y_free < 0) y_free = '0;
      end else begin
        y_free = f_dy;
        y_row  = nr_d;
        y_scan = (nr_d != cr_d);
        y_blk  = coord_t'(nr_d * CELL_H) - y2 - coord_t'(1);
      end
    end
  end

  // ---------------- scan index ----------------
  always_ff @(posedge clk) begin
    if (cmd.start_x) begin
      idx    <= r0;
      axis_y <= 1'b0;
    end else if (cmd.start_y) begin
      idx    <= c0;
      axis_y <= 1'b1;
    end else if (cmd.scan_next) begin
      idx <= idx + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      x_hit <= 1'b0;
      y_hit <= 1'b0;
    end else begin
      if (cmd.hit_x) x_hit <= 1'b1;
      if (cmd.hit_y) y_hit <= 1'b1;
    end
  end

  // cells past the grid edge are passable, so the scan stops at the edge
  assign scan_end = axis_y ? c1 : r1;
  assign scan_lim = axis_y ? idx_t'(GRID_COLS - 1) : idx_t'(GRID_ROWS - 1);

  always_comb begin
    if (axis_y) mask_sel = (f_dy < 0) ? masks.top_solid : masks.bottom_solid;
    else        mask_sel = (f_dx < 0) ? masks.right_solid : masks.left_solid;
  end

  // ---------------- grid memory ----------------
  assign req_ok    = (32'(req.cell_col) < GRID_COLS) && (32'(req.cell_row) < GRID_ROWS);
  assign cell_ok   = (32'(f_col) < GRID_COLS) && (32'(f_row) < GRID_ROWS);
  assign req_addr  = addr_t'(32'(req.cell_row) * GRID_COLS + 32'(req.cell_col));
  assign cell_addr = addr_t'(32'(f_row) * GRID_COLS + 32'(f_col));
  assign scan_addr = axis_y ?
                     addr_t'(32'(y_row) * GRID_COLS + 32'(idx)) :
                     addr_t'(32'(idx) * GRID_COLS + 32'(x_col));
  assign raddr     = cmd.re_cell ? cell_addr : scan_addr;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      grid[clr_addr] <= 8'd0;
    end else if (cmd.acc && (req.func == FN_WRITE) && req_ok) begin
      grid[req_addr] <= req.cell_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re_cell || cmd.re_scan) rd_data <= grid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr && (clr_addr != addr_t'(GRID_DEPTH - 1))) begin
      clr_addr <= clr_addr + addr_t'(1);
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts.func      = f_func;
    sts.need_x    = x_scan && (r0 < idx_t'(GRID_ROWS));
    sts.need_y    = y_scan && (c0 < idx_t'(GRID_COLS));
    sts.hit       = (rd_data & mask_sel) != 8'd0;
    sts.scan_last = (idx >= scan_end) || (idx >= scan_lim);
    sts.clr_last  = (clr_addr == addr_t'(GRID_DEPTH - 1));
  end

  // ---------------- result register ----------------
  assign dx_fin = x_hit ? x_blk : x_free;
  assign dy_fin = y_hit ? y_blk : y_free;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.clipped_dx <= (f_func == FN_CLIP) ? dx_fin[3:0] : 4'd0;
      rsp.clipped_dy <= (f_func == FN_CLIP) ? dy_fin[3:0] : 4'd0;
      rsp.read_flags <= ((f_func == FN_READ) && cell_ok) ? rd_data : 8'd0;
    end
  end

endmodule

FILE: bench/tile_grid_motion_clip_tb.sv
// Self-checking bench for tile_grid_motion_clip: directed and random cell
// writes, reads and motion clips, checked against a cycle-free predictor.
// Depends on tgmc_pkg and the tile_grid_motion_clip RTL.
module tile_grid_motion_clip_tb;
  import tgmc_pkg::*;

  // Run shape
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int WATCHDOG    = 60000;  // covers the clearing sweep of all 16384 cells
  localparam int MAX_SHOWN   = 10;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_bus = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tile_grid_motion_clip dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_bus),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  wire req_xfer = req_valid && !req_stall;
  wire rsp_xfer = rsp_valid && !rsp_stall;

  // Bench-side image of the block: cell flags and direction masks
  logic [7:0] grid_img [GRID_ROWS][GRID_COLS];
  masks_t     solid_masks = {RST_MASK_LEFT, RST_MASK_RIGHT, RST_MASK_TOP, RST_MASK_BOTTOM};

  req_t req_backlog [$];   // items not yet offered
  rsp_t rsp_due     [$];   // results owed by the block, oldest first

  int fail_cnt = 0;
  int idle_cycles = 0;
  int req_pause = 0;
  int rsp_hold = 0;
  int next_hold;
  bit req_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  rsp_t exp_rsp;

  initial begin
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++)
        grid_img[r][c] = 8'h00;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Cells off the grid read as empty
  function automatic logic [7:0] cell_val(int col, int row);
    if (col < 0 || row < 0 || col >= GRID_COLS || row >= GRID_ROWS) return 8'h00;
    return grid_img[row][col];
  endfunction

  function automatic bit col_hits(int col, int r0, int r1, logic [7:0] m);
    for (int r = r0; r <= r1; r++)
      if ((cell_val(col, r) & m) != 8'h00) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit row_hits(int row, int c0, int c1, logic [7:0] m);
    for (int c = c0; c <= c1; c++)
      if ((cell_val(c, row) & m) != 8'h00) return 1'b1;
    return 1'b0;
  endfunction

  // Result of one request; a write also updates the grid image
  function automatic rsp_t grid_response(req_t r);
    rsp_t o;
    int   x, y, x2, y2, r0, r1, c0, c1, dx, dy, nc, cc;
    o = '0;
    case (r.func)
      FN_WRITE: grid_img[r.cell_row][r.cell_col] = r.cell_flags;
      FN_READ:  o.read_flags = grid_img[r.cell_row][r.cell_col];
      FN_CLIP: begin
        x  = int'(r.rect_x);
        y  = int'(r.rect_y);
        // zero size counts as one pixel
        x2 = x + ((r.rect_w == 0) ? 1 : int'(r.rect_w)) - 1;
        y2 = y + ((r.rect_h == 0) ? 1 : int'(r.rect_h)) - 1;
        r0 = y / CELL_H;
        r1 = y2 / CELL_H;
        c0 = x / CELL_W;
        c1 = x2 / CELL_W;
        dx = int'(r.move_dx);
        dy = int'(r.move_dy);
        // steps beyond one cell saturate
        if (dx > CELL_W) dx = CELL_W;
        else if (dx < -CELL_W) dx = -CELL_W;
        if (dy > CELL_H) dy = CELL_H;
        else if (dy < -CELL_H) dy = -CELL_H;

        // both axes are judged from the original position
        if (dx < 0) begin
          if (x + dx < 0) dx = -x;
          else begin
            nc = (x + dx) / CELL_W;
            cc = x / CELL_W;
            if (nc != cc && col_hits(nc, r0, r1, solid_masks.right_solid))
              dx = cc * CELL_W - x;
          end
        end else if (dx > 0) begin
          if (x2 + dx >= PIX_W) begin
            dx = PIX_W - 1 - x2;
            if (dx < 0) dx = 0;      // already at or past the right edge
          end else begin
            nc = (x2 + dx) / CELL_W;
            cc = x2 / CELL_W;
            if (nc != cc && col_hits(nc, r0, r1, solid_masks.left_solid))
              dx = nc * CELL_W - (x2 + 1);
          end
        end

        if (dy < 0) begin
          if (y + dy < 0) dy = -y;
          else begin
            nc = (y + dy) / CELL_H;
            cc = y / CELL_H;
            if (nc != cc && row_hits(nc, c0, c1, solid_masks.top_solid))
              dy = cc * CELL_H - y;
          end
        end else if (dy > 0) begin
          if (y2 + dy >= PIX_H) begin
            dy = PIX_H - 1 - y2;
            if (dy < 0) dy = 0;
          end else begin
            nc = (y2 + dy) / CELL_H;
            cc = y2 / CELL_H;
            if (nc != cc && row_hits(nc, c0, c1, solid_masks.bottom_solid))
              dy = nc * CELL_H - (y2 + 1);
          end
        end
        o.clipped_dx = dx[3:0];
        o.clipped_dy = dy[3:0];
      end
      default: ;  // unused func: all result fields zero
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: one item per transfer, random gap after each
  // ---------------------------------------------------------------------------
  function automatic int pause_draw(bit on);
    return on ? int'($urandom_range(0, 6)) : 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_pause <= 0;
    end else if (!req_valid || !req_stall) begin
      // the item on the bus (if any) is taken at this edge
      if (req_valid) rsp_due.push_back(grid_response(req_bus));
      if (req_pause != 0) begin
        req_valid <= 1'b0;
        req_pause <= req_pause - 1;
      end else if (req_backlog.size() != 0) begin
        req_bus   <= req_backlog.pop_front();
        req_valid <= 1'b1;
        req_pause <= pause_draw(req_idle_on);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare with the oldest owed result, stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_hold  <= 0;
    end else if (rsp_xfer) begin
      if (rsp_due.size() == 0) begin
        if (fail_cnt < MAX_SHOWN)
          $display("unexpected result: dx %0d dy %0d flags %02h",
                   $signed(rsp.clipped_dx), $signed(rsp.clipped_dy), rsp.read_flags);
        fail_cnt++;
      end else begin
        exp_rsp = rsp_due.pop_front();
        if (rsp.clipped_dx !== exp_rsp.clipped_dx || rsp.clipped_dy !== exp_rsp.clipped_dy ||
            rsp.read_flags !== exp_rsp.read_flags) begin
          if (fail_cnt < MAX_SHOWN)
            $display({"result mismatch: expected dx %0d dy %0d flags %02h, ",
                      "got dx %0d dy %0d flags %02h"},
                     $signed(exp_rsp.clipped_dx), $signed(exp_rsp.clipped_dy),
                     exp_rsp.read_flags,
                     $signed(rsp.clipped_dx), $signed(rsp.clipped_dy), rsp.read_flags);
          fail_cnt++;
        end
      end
      next_hold = pause_draw(rsp_idle_on);
      rsp_hold  <= next_hold;
      rsp_stall <= (next_hold != 0);
    end else if (rsp_hold != 0) begin
      rsp_hold  <= rsp_hold - 1;
      rsp_stall <= (rsp_hold > 1);
    end
  end

  // Watchdog: too long with no transfer on either channel
  always @(posedge clk) begin
    if (rst || req_xfer || rsp_xfer) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("tile_grid_motion_clip_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access (setup cycle, then access cycle)
  // ---------------------------------------------------------------------------

  // For a read, val is the value the register must return
  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? {24'd0, val} : 32'd0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // access completes at this edge
    if (pready !== 1'b1) begin
      if (fail_cnt < MAX_SHOWN)
        $display("register %0d access: pready low", idx);
      fail_cnt++;
    end
    if (!wr && prdata[7:0] !== val) begin
      if (fail_cnt < MAX_SHOWN)
        $display("register %0d readback: expected %02h, got %02h", idx, val, prdata[7:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_masks(input masks_t m);
    apb_access(1'b1, REG_MASK_LEFT,   m.left_solid);
    apb_access(1'b1, REG_MASK_RIGHT,  m.right_solid);
    apb_access(1'b1, REG_MASK_TOP,    m.top_solid);
    apb_access(1'b1, REG_MASK_BOTTOM, m.bottom_solid);
    solid_masks = m;
    apb_access(1'b0, REG_MASK_LEFT,   m.left_solid);
    apb_access(1'b0, REG_MASK_RIGHT,  m.right_solid);
    apb_access(1'b0, REG_MASK_TOP,    m.top_solid);
    apb_access(1'b0, REG_MASK_BOTTOM, m.bottom_solid);
  endtask

  // Idle means nothing queued, nothing on the bus and nothing owed.
  // Checked at the falling edge so the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t pack_req(logic [1:0] fn, int col, int row, int flags,
                                    int x, int y, int w, int h, int dx, int dy);
    req_t r;
    r.func       = fn;
    r.cell_col   = col[7:0];
    r.cell_row   = row[5:0];
    r.cell_flags = flags[7:0];
    r.rect_x     = x[9:0];
    r.rect_y     = y[7:0];
    r.rect_w     = w[10:0];
    r.rect_h     = h[8:0];
    r.move_dx    = dx[3:0];
    r.move_dy    = dy[3:0];
    return r;
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.func       = 2'($urandom);
    r.cell_col   = 8'($urandom);
    r.cell_row   = 6'($urandom);
    r.cell_flags = 8'($urandom);
    r.rect_x     = 10'($urandom);
    r.rect_y     = 8'($urandom);
    r.rect_w     = 11'($urandom);
    r.rect_h     = 9'($urandom);
    r.move_dx    = 4'($urandom);
    r.move_dy    = 4'($urandom);
    return r;
  endfunction

  function automatic int jitter(int base, int span, int hi);
    int v;
    v = base - span + int'($urandom_range(0, 2 * span));
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Flag byte or mask: half one-hot, half any byte
  function automatic logic [7:0] flag_pick();
    return $urandom_range(0, 1) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
  endfunction

  // Picks a window of the grid, seeds it with solid cells, then mostly clips
  // small rectangles around it; some reads, more writes and pure noise.
  task automatic queue_phase(input int n);
    int   bc, br, sel;
    req_t r;
    sel = $urandom_range(0, 5);
    bc  = (sel == 0) ? 0 : ((sel == 1) ? GRID_COLS - 1 : int'($urandom_range(0, GRID_COLS - 1)));
    sel = $urandom_range(0, 5);
    br  = (sel == 0) ? 0 : ((sel == 1) ? GRID_ROWS - 1 : int'($urandom_range(0, GRID_ROWS - 1)));
    for (int i = 0; i < n; i++) begin
      r   = noise_req();
      sel = $urandom_range(0, 99);
      if (i < 8 || sel < 12) begin
        r.func       = FN_WRITE;
        r.cell_col   = 8'(jitter(bc, 3, GRID_COLS - 1));
        r.cell_row   = 6'(jitter(br, 3, GRID_ROWS - 1));
        r.cell_flags = flag_pick();
      end else if (sel < 22) begin
        r.func = FN_READ;
        if (sel < 17) begin
          r.cell_col = 8'(jitter(bc, 3, GRID_COLS - 1));
          r.cell_row = 6'(jitter(br, 3, GRID_ROWS - 1));
        end
      end else if (sel < 90) begin
        r.func   = FN_CLIP;
        r.rect_x = 10'(jitter(bc * CELL_W, 16, PIX_W - 1));
        r.rect_y = 8'(jitter(br * CELL_H, 16, PIX_H - 1));
        // a few large rectangles for long scans, the rest sprite-sized
        if ($urandom_range(0, 29) == 0) begin
          r.rect_w = 11'($urandom_range(0, 2047));
          r.rect_h = 9'($urandom_range(0, 511));
        end else begin
          r.rect_w = 11'($urandom_range(1, 12));
          r.rect_h = 9'($urandom_range(1, 12));
        end
        if ($urandom_range(0, 7) != 0) begin
          r.move_dx = 4'(int'($urandom_range(0, 8)) - 4);
          r.move_dy = 4'(int'($urandom_range(0, 8)) - 4);
        end
      end
      req_backlog.push_back(r);
    end
  endtask

  masks_t phase_masks;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset masks: left 1, right 2, top 4, bottom 8.
    // Taken once the clearing sweep ends.
    req_backlog.push_back(pack_req(FN_WRITE, 0, 0, 8'hFF, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_WRITE, 255, 63, 8'hAA, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_READ, 0, 0, 0, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_READ, 255, 63, 0, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_READ, 17, 9, 0, 0, 0, 1, 1, 0, 0));    // never written
    // step into solid corner cell from its right side
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 4, 0, 4, 4, -4, 0));
    req_backlog.push_back(pack_req(FN_WRITE, 5, 5, 8'h0F, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_READ, 5, 5, 0, 0, 0, 1, 1, 0, 0));
    // unused func with every field at its top
    req_backlog.push_back(pack_req(FN_NOP, 255, 63, 255, 1023, 255, 2047, 511, -1, -1));
    // zero size at the top-left edge
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 0, 0, 0, 0, -4, -4));
    // oversize steps saturate; the first then hits the left and top edges
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 2, 2, 1, 1, -8, -8));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 100, 100, 3, 3, 7, 7));
    // right and bottom edges: flush, past the edge, and partial room
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 1020, 252, 4, 4, 4, 4));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 1023, 255, 2047, 511, 4, 4));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 1018, 250, 4, 4, 4, 4));
    // each direction blocked by cell (5,5)
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 15, 20, 4, 4, 4, 0));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 25, 20, 2, 2, -4, 0));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 20, 16, 2, 2, 0, 4));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 20, 26, 2, 2, 0, -4));
    // tall and wide scans running off the grid
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 15, 0, 4, 511, 4, 0));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 0, 16, 2047, 2, 0, 4));
    // diagonal next to the block, then the block cleared
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 15, 16, 4, 2, 4, 4));
    req_backlog.push_back(pack_req(FN_WRITE, 5, 5, 8'h00, 0, 0, 1, 1, 0, 0));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 15, 20, 4, 4, 4, 0));
    req_backlog.push_back(pack_req(FN_CLIP, 0, 0, 0, 20, 20, 1, 1, 1, 1));

    // Random phases, each under its own mask setting and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       phase_masks = {RST_MASK_LEFT, RST_MASK_RIGHT, RST_MASK_TOP, RST_MASK_BOTTOM};
        1:       phase_masks = '0;
        2:       phase_masks = '1;
        default: phase_masks = {flag_pick(), flag_pick(), flag_pick(), flag_pick()};
      endcase
      set_masks(phase_masks);
      req_idle_on = (ph % 2) == 1;
      rsp_idle_on = (ph % 4) >= 2;
      queue_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (24) @(posedge clk);
    if (fail_cnt == 0 && rsp_due.size() == 0) begin
      $display("tile_grid_motion_clip_tb passed");
    end else begin
      $display("tile_grid_motion_clip_tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tgmc_pkg.sv
rtl/tgmc_regs.sv
rtl/tgmc_ctrl.sv
rtl/tgmc_dp.sv
rtl/tile_grid_motion_clip.sv
bench/tile_grid_motion_clip_tb.sv
